>>> hdl/fos_pkg.sv
// fos_pkg: shared defaults and controller/datapath command and status types
// for the frequency order sorter; depends on nothing
`default_nettype none

package fos_pkg;

	localparam int DEPTH_DEF       = 64;
	localparam int VALUE_WIDTH_DEF = 16;

	// commands from the sequencer to the datapath
	typedef struct packed {
		logic load_we;     // store an incoming sample
		logic cnt_cap;     // capture the reference value, clear the tally
		logic cnt_issue;   // read one element for the equality tally
		logic occ_we;      // write the tally into the occurrence store
		logic sel_issue;   // read one element for the minimum search
		logic sel_first;   // first read of a search round, forget the best
		logic clear_prev;  // start of emission, no group emitted yet
		logic push;        // move the best element into the output register
		logic push_last;   // that beat closes the set
	} fos_cmd_t;

	// status from the datapath back to the sequencer
	typedef struct packed {
		logic out_free;    // output register can take a beat this cycle
	} fos_stat_t;

endpackage

`default_nettype wire

>>> hdl/fos_if.sv
// fos_in_if, fos_out_if: valid/ready channels of the frequency order sorter
// depends on fos_pkg for default widths
`default_nettype none

interface fos_in_if #(
	parameter int VALUE_WIDTH = fos_pkg::VALUE_WIDTH_DEF
);
	logic                          valid;
	logic                          ready;
	logic signed [VALUE_WIDTH-1:0] sample_value;
	logic                          final_item;

	modport source (output valid, output sample_value, output final_item, input ready);
	modport sink   (input valid, input sample_value, input final_item, output ready);
endinterface

interface fos_out_if #(
	parameter int VALUE_WIDTH = fos_pkg::VALUE_WIDTH_DEF,
	parameter int POS_W       = $clog2(fos_pkg::DEPTH_DEF)
);
	logic                          valid;
	logic                          ready;
	logic signed [VALUE_WIDTH-1:0] group_value;
	logic        [POS_W-1:0]       original_position;
	logic                          end_of_run;

	modport source (output valid, output group_value, output original_position,
		output end_of_run, input ready);
	modport sink   (input valid, input group_value, input original_position,
		input end_of_run, output ready);
endinterface

`default_nettype wire

>>> hdl/fos_ram.sv
// fos_ram: generic single write port, single read port ram with registered read
// depends on nothing
`default_nettype none

module fos_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64,
	localparam int AW   = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

>>> hdl/fos_ctrl.sv
// fos_ctrl: sequencer of the frequency order sorter (load, tally, select, emit)
// depends on fos_pkg for the command and status types
`default_nettype none

module fos_ctrl #(
	parameter int DEPTH = fos_pkg::DEPTH_DEF,
	localparam int POS_W = $clog2(DEPTH),
	localparam int CNT_W = $clog2(DEPTH + 1)
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	input  wire logic                in_final,
	output logic                     in_ready,
	output fos_pkg::fos_cmd_t        cmd,
	input  wire fos_pkg::fos_stat_t  stat,
	output logic [POS_W-1:0]         wr_addr,
	output logic [POS_W-1:0]         rd_addr
);

	typedef enum logic [3:0] {
		S_LOAD,
		S_CNT_FETCH,
		S_CNT_CAPT,
		S_CNT_SCAN,
		S_CNT_DRAIN,
		S_CNT_WRITE,
		S_SEL_SCAN,
		S_SEL_DRAIN,
		S_SEL_PUSH
	} state_t;

	state_t           state_q;
	logic [CNT_W-1:0] n_q;
	logic [POS_W-1:0] i_q;
	logic [POS_W-1:0] j_q;
	logic [POS_W-1:0] k_q;
	logic [POS_W-1:0] last_idx;
	logic             accept;
	logic             room;

	assign last_idx = POS_W'(n_q - CNT_W'(1));
	assign in_ready = (state_q == S_LOAD);
	assign accept   = in_valid && in_ready;
	assign room     = (n_q < CNT_W'(DEPTH));

	assign wr_addr = (state_q == S_LOAD) ? n_q[POS_W-1:0] : i_q;
	assign rd_addr = (state_q == S_CNT_FETCH) ? i_q : j_q;

	always_comb begin
		cmd            = '0;
		cmd.load_we    = accept && room;
		cmd.cnt_cap    = (state_q == S_CNT_CAPT);
		cmd.cnt_issue  = (state_q == S_CNT_SCAN);
		cmd.occ_we     = (state_q == S_CNT_WRITE);
		cmd.clear_prev = (state_q == S_CNT_WRITE) && (i_q == last_idx);
		cmd.sel_issue  = (state_q == S_SEL_SCAN);
		cmd.sel_first  = (state_q == S_SEL_SCAN) && (j_q == '0);
		cmd.push       = (state_q == S_SEL_PUSH) && stat.out_free;
		cmd.push_last  = (k_q == last_idx);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_LOAD;
			n_q     <= '0;
			i_q     <= '0;
			j_q     <= '0;
			k_q     <= '0;
		end else begin
			unique case (state_q)
				S_LOAD: begin
					if (accept) begin
						if (room) begin
							n_q <= n_q + CNT_W'(1);
						end
						if (in_final) begin
							i_q     <= '0;
							state_q <= S_CNT_FETCH;
						end
					end
				end
				S_CNT_FETCH: begin
					state_q <= S_CNT_CAPT;
				end
				S_CNT_CAPT: begin
					j_q     <= '0;
					state_q <= S_CNT_SCAN;
				end
				S_CNT_SCAN: begin
					if (j_q == last_idx) begin
						state_q <= S_CNT_DRAIN;
					end else begin
						j_q <= j_q + POS_W'(1);
					end
				end
				S_CNT_DRAIN: begin
					state_q <= S_CNT_WRITE;
				end
				S_CNT_WRITE: begin
					if (i_q == last_idx) begin
						k_q     <= '0;
						j_q     <= '0;
						state_q <= S_SEL_SCAN;
					end else begin
						i_q     <= i_q + POS_W'(1);
						state_q <= S_CNT_FETCH;
					end
				end
				S_SEL_SCAN: begin
					if (j_q == last_idx) begin
						state_q <= S_SEL_DRAIN;
					end else begin
						j_q <= j_q + POS_W'(1);
					end
				end
				S_SEL_DRAIN: begin
					state_q <= S_SEL_PUSH;
				end
				S_SEL_PUSH: begin
					if (stat.out_free) begin
						if (k_q == last_idx) begin
							n_q     <= '0;
							state_q <= S_LOAD;
						end else begin
							k_q     <= k_q + POS_W'(1);
							j_q     <= '0;
							state_q <= S_SEL_SCAN;
						end
					end
				end
				default: begin
					state_q <= S_LOAD;
				end
			endcase
		end
	end

	// held element count never passes the store depth
	assert property (@(posedge clk) disable iff (!arst_n) n_q <= CNT_W'(DEPTH))
		else $error("element count above depth");

	// tally and search only run over a non-empty set
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_LOAD) |-> (n_q != '0))
		else $error("processing an empty set");

	// a beat is only pushed into a free output register
	assert property (@(posedge clk) disable iff (!arst_n) cmd.push |-> stat.out_free)
		else $error("push into an occupied output register");

endmodule

`default_nettype wire

>>> hdl/fos_dp.sv
// fos_dp: datapath of the frequency order sorter: value and occurrence stores,
// equality tally, ordered minimum search and output register; uses fos_pkg, fos_ram
`default_nettype none

module fos_dp #(
	parameter int DEPTH       = fos_pkg::DEPTH_DEF,
	parameter int VALUE_WIDTH = fos_pkg::VALUE_WIDTH_DEF,
	localparam int POS_W      = $clog2(DEPTH),
	localparam int CNT_W      = $clog2(DEPTH + 1),
	localparam int KEY_W      = CNT_W + VALUE_WIDTH + POS_W
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire fos_pkg::fos_cmd_t             cmd,
	output fos_pkg::fos_stat_t                 stat,
	input  wire logic        [POS_W-1:0]       wr_addr,
	input  wire logic        [POS_W-1:0]       rd_addr,
	input  wire logic signed [VALUE_WIDTH-1:0] in_value,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic signed      [VALUE_WIDTH-1:0] out_value,
	output logic             [POS_W-1:0]       out_pos,
	output logic                               out_last
);

	logic [VALUE_WIDTH-1:0] val_rd;
	logic [CNT_W-1:0]       occ_rd;

	logic                   cnt_s1;
	logic                   sel_s1;
	logic [POS_W-1:0]       addr_s1;

	logic [VALUE_WIDTH-1:0] ref_val_q;
	logic [CNT_W-1:0]       tally_q;

	logic                   has_prev_q;
	logic [KEY_W-1:0]       prev_key_q;
	logic                   best_valid_q;
	logic [KEY_W-1:0]       best_key_q;
	logic [VALUE_WIDTH-1:0] best_val_q;

	logic                   out_valid_q;
	logic [VALUE_WIDTH-1:0] out_value_q;
	logic [POS_W-1:0]       out_pos_q;
	logic                   out_last_q;

	logic [KEY_W-1:0]       cand_key;
	logic                   take;

	fos_ram #(
		.WIDTH (VALUE_WIDTH),
		.DEPTH (DEPTH)
	) u_value_ram (
		.clk   (clk),
		.we    (cmd.load_we),
		.waddr (wr_addr),
		.wdata (in_value),
		.raddr (rd_addr),
		.rdata (val_rd)
	);

	fos_ram #(
		.WIDTH (CNT_W),
		.DEPTH (DEPTH)
	) u_occ_ram (
		.clk   (clk),
		.we    (cmd.occ_we),
		.waddr (wr_addr),
		.wdata (tally_q),
		.raddr (rd_addr),
		.rdata (occ_rd)
	);

	// order: count, then value as signed (sign bit flipped), then position
	assign cand_key = {occ_rd, ~val_rd[VALUE_WIDTH-1], val_rd[VALUE_WIDTH-2:0], addr_s1};
	assign take     = sel_s1
		&& (!has_prev_q || (cand_key > prev_key_q))
		&& (!best_valid_q || (cand_key < best_key_q));

	assign stat.out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_s1       <= 1'b0;
			sel_s1       <= 1'b0;
			has_prev_q   <= 1'b0;
			best_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			cnt_s1 <= cmd.cnt_issue;
			sel_s1 <= cmd.sel_issue;
			if (cmd.clear_prev) begin
				has_prev_q <= 1'b0;
			end else if (cmd.push) begin
				has_prev_q <= 1'b1;
			end
			if (cmd.sel_first) begin
				best_valid_q <= 1'b0;
			end else if (take) begin
				best_valid_q <= 1'b1;
			end
			if (cmd.push) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		addr_s1 <= rd_addr;
		if (cmd.cnt_cap) begin
			ref_val_q <= val_rd;
			tally_q   <= '0;
		end else if (cnt_s1 && (val_rd == ref_val_q)) begin
			tally_q <= tally_q + CNT_W'(1);
		end
		if (take) begin
			best_key_q <= cand_key;
			best_val_q <= val_rd;
		end
		if (cmd.push) begin
			prev_key_q  <= best_key_q;
			out_value_q <= best_val_q;
			out_pos_q   <= best_key_q[POS_W-1:0];
			out_last_q  <= cmd.push_last;
		end
	end

	assign out_valid = out_valid_q;
	assign out_value = out_value_q;
	assign out_pos   = out_pos_q;
	assign out_last  = out_last_q;

	// a search round always finds an element before it is pushed
	assert property (@(posedge clk) disable iff (!arst_n) cmd.push |-> best_valid_q)
		else $error("push without a selected element");

	// emitted keys strictly increase within a set
	assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.push && has_prev_q) |-> (best_key_q > prev_key_q))
		else $error("emission order not increasing");

	// a pushed beat is offered on the next cycle
	assert property (@(posedge clk) disable iff (!arst_n) cmd.push |=> out_valid_q)
		else $error("pushed beat not offered");

endmodule

`default_nettype wire

>>> hdl/frequency_order_sorter.sv
// frequency_order_sorter: top level, joins the sequencer and the datapath
// depends on fos_pkg, fos_if (fos_in_if, fos_out_if), fos_ctrl, fos_dp, fos_ram
`default_nettype none

// Loads a set of signed values, one beat per cycle on samples, until a beat
// with final_item set; beats past DEPTH in one set are dropped, but a dropped
// final beat still closes the set. The block then emits every held element on
// pairs as (group_value, original_position): groups of equal value ordered by
// ascending occurrence count, equal counts by ascending value, positions inside
// a group ascending, and end_of_run set on the last beat. After the final beat,
// a tally pass and then a search pass run over the held elements; the search
// pass also waits on any output stall. Both passes run through the single
// read port of the value store: each element is compared against every other
// one in turn for its count, and each emitted beat comes from a full scan for
// the smallest key above the one emitted last. samples is not ready while a
// set is processed; it opens again as soon as the last beat is in the output
// register, so loading the next set overlaps with that beat waiting on pairs.
// No clearing pass is needed after reset.

module frequency_order_sorter #(
	parameter int DEPTH       = fos_pkg::DEPTH_DEF,
	parameter int VALUE_WIDTH = fos_pkg::VALUE_WIDTH_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	fos_in_if.sink   samples,
	fos_out_if.source pairs
);

	localparam int POS_W = $clog2(DEPTH);

	// control and status between sequencer and datapath
	fos_pkg::fos_cmd_t  cmd;
	fos_pkg::fos_stat_t stat;

	// store addresses chosen by the sequencer
	logic [POS_W-1:0] wr_addr;
	logic [POS_W-1:0] rd_addr;

	// sequencer: load count, tally pass, search rounds and emission pacing
	fos_ctrl #(
		.DEPTH (DEPTH)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (samples.valid),
		.in_final (samples.final_item),
		.in_ready (samples.ready),
		.cmd      (cmd),
		.stat     (stat),
		.wr_addr  (wr_addr),
		.rd_addr  (rd_addr)
	);

	// datapath: stores, equality tally, ordered minimum search, output register
	fos_dp #(
		.DEPTH       (DEPTH),
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.wr_addr   (wr_addr),
		.rd_addr   (rd_addr),
		.in_value  (samples.sample_value),
		.out_valid (pairs.valid),
		.out_ready (pairs.ready),
		.out_value (pairs.group_value),
		.out_pos   (pairs.original_position),
		.out_last  (pairs.end_of_run)
	);

endmodule

`default_nettype wire
